// File: sv/rof_pkg.sv
// rof_pkg: shared widths, register indexes, reset values and stream layout
// for the range outlier filter core
// no dependencies
package rof_pkg;

    // payload field widths
    localparam int unsigned SID_W   = 2;
    localparam int unsigned DIST_W  = 17;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned MS_W    = 32;
    localparam int unsigned EXP_W   = 16;

    // stream packing
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 3;

    // configuration port
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 17;

    localparam logic [CFG_AW-1:0] CFG_BLIND_ZONE    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_RANGE     = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MAX_CHANGE    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_MAX_REJECTS   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_EXPIRE_MS     = 3'd4;

    localparam logic [DIST_W-1:0] RST_BLIND_ZONE  = 17'd320;
    localparam logic [DIST_W-1:0] RST_MAX_RANGE   = 17'd64000;
    localparam logic [DIST_W-1:0] RST_MAX_CHANGE  = 17'd8000;
    localparam logic [CNT_W-1:0]  RST_MAX_REJECTS = 8'd5;
    localparam logic [EXP_W-1:0]  RST_EXPIRE_MS   = 16'd1000;

    // default sizing
    localparam int unsigned SENSORS_DEF      = 4;
    localparam int unsigned FILTER_DEPTH_DEF = 4;

endpackage

// File: sv/range_outlier_filter_core.sv
// range_outlier_filter_core: per-sensor outlier rejection and moving average
// for range readings, one reading per cycle
// depends on rof_pkg
//
// usage
//   s_axis carries one reading: tuser holds sensor id and the success flag,
//   tdata holds raw distance (Q4 mm) and the millisecond timestamp.
//   m_axis carries one result per reading: tuser holds sensor id and the
//   stale flag, tdata holds the filtered or held distance and the current
//   consecutive reject count.
//   the configuration port writes one register per cycle while i_cfg_we is
//   high; registers should only change while no transfer is in flight.
// latency and throughput
//   a result appears on m_axis the cycle after its input transfer. the
//   per-sensor state and running sum are updated in that same cycle, so a
//   new reading can be taken every cycle, even for the same sensor. the path
//   is one running-sum update plus one reciprocal multiply for the average.
// reset and stall
//   i_rst_n low for one edge loads register defaults and clears all sensor
//   state; the sample ring needs no clearing, the first accepted reading of a
//   sensor fills its row. while m_axis_tready is low the result holds and
//   s_axis_tready drops; a new transfer is taken in the cycle the result goes.
module range_outlier_filter_core #(
    parameter int unsigned SENSORS      = rof_pkg::SENSORS_DEF,
    parameter int unsigned FILTER_DEPTH = rof_pkg::FILTER_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_cfg_we,
    input  logic [rof_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [rof_pkg::CFG_DW-1:0]     i_cfg_wdata,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // raw_distance [16:0], now_ms [48:17], zero fill
    input  logic [rof_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // sensor_num [1:0], measure_ok [2]
    input  logic [rof_pkg::S_TUSER_W-1:0]  s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // distance_out [16:0], rejects_now [24:17], zero fill
    output logic [rof_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // out_sensor_num [1:0], stale [2]
    output logic [rof_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    localparam int unsigned DW      = rof_pkg::DIST_W;
    localparam int unsigned CW      = rof_pkg::CNT_W;
    localparam int unsigned MW      = rof_pkg::MS_W;
    localparam int unsigned IDX_W   = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int unsigned POS_W   = $clog2(FILTER_DEPTH);
    localparam int unsigned SUM_W   = DW + POS_W;
    // exact floor division by reciprocal: m = ceil(2^(N+l) / d)
    localparam int unsigned SH      = SUM_W + POS_W;
    localparam int unsigned RECIP_W = SUM_W + 2;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SH) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;

    // configuration registers
    logic [DW-1:0]             r_blind_zone;
    logic [DW-1:0]             r_max_range;
    logic [DW-1:0]             r_max_change;
    logic [CW-1:0]             r_max_rejects;
    logic [rof_pkg::EXP_W-1:0] r_expire_ms;

    // per-sensor state
    logic [DW-1:0]     r_ring   [SENSORS][FILTER_DEPTH];
    logic [POS_W-1:0]  r_pos    [SENSORS];
    logic [SUM_W-1:0]  r_sum    [SENSORS];
    logic [DW-1:0]     r_last   [SENSORS];
    logic [MW-1:0]     r_ms     [SENSORS];
    logic [CW-1:0]     r_rej    [SENSORS];
    logic [SENSORS-1:0] r_filled;
    logic [SENSORS-1:0] r_has;
    logic [SENSORS-1:0] r_stale;

    // result register
    logic              r_out_valid;
    logic [1:0]        r_out_sid;
    logic [DW-1:0]     r_out_dist;
    logic              r_out_stale;
    logic [CW-1:0]     r_out_rej;

    // input fields
    logic [1:0]        in_sid;
    logic              in_ok;
    logic [DW-1:0]     in_raw;
    logic [MW-1:0]     in_now;
    logic              s_fire;
    logic              sid_valid;
    logic [IDX_W-1:0]  sel;

    // next values for the selected sensor
    logic              do_accept;
    logic [DW-1:0]     n_dist;
    logic              n_stale;
    logic [CW-1:0]     n_rej;
    logic [SUM_W-1:0]  n_sum;
    logic [POS_W-1:0]  n_pos;
    logic [PROD_W-1:0] avg_prod;

    assign in_sid = s_axis_tuser[1:0];
    assign in_ok  = s_axis_tuser[2];
    assign in_raw = s_axis_tdata[DW-1:0];
    assign in_now = s_axis_tdata[DW+MW-1:DW];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign sid_valid     = 32'(in_sid) < SENSORS;
    assign sel           = IDX_W'(in_sid);

    always_comb begin
        logic          range_bad;
        logic [DW-1:0] diff;
        logic [DW-1:0] last_v;
        logic [CW-1:0] rej_inc;
        logic [MW-1:0] gap;
        logic          filled;
        logic          has;

        last_v   = r_last[sel];
        filled   = r_filled[sel];
        has      = r_has[sel];
        rej_inc  = r_rej[sel] + CW'(1);
        range_bad = (in_raw < r_blind_zone) || (in_raw > r_max_range);
        diff     = (in_raw > last_v) ? (in_raw - last_v) : (last_v - in_raw);
        gap      = in_now - r_ms[sel];

        do_accept = 1'b0;
        n_dist    = '0;
        n_stale   = r_stale[sel];
        n_rej     = r_rej[sel];

        if (in_ok) begin
            n_stale = 1'b0;
            if (range_bad || (has && diff > r_max_change)) begin
                if (rej_inc < r_max_rejects && has) begin
                    n_rej  = rej_inc;
                    n_dist = last_v;
                end else begin
                    do_accept = 1'b1;
                end
            end else begin
                do_accept = 1'b1;
            end
        end else if (has) begin
            n_dist = last_v;
            if (gap > MW'(r_expire_ms)) begin
                n_stale = 1'b1;
            end
        end

        // running sum, first fill loads the whole ring with this reading
        if (filled) begin
            n_sum = r_sum[sel] - SUM_W'(r_ring[sel][r_pos[sel]]) + SUM_W'(in_raw);
        end else begin
            n_sum = SUM_W'(in_raw) * SUM_W'(FILTER_DEPTH);
        end
        n_pos    = (r_pos[sel] == POS_W'(FILTER_DEPTH - 1)) ? '0 : r_pos[sel] + POS_W'(1);
        avg_prod = PROD_W'(n_sum) * PROD_W'(RECIP);

        if (do_accept) begin
            n_rej  = '0;
            n_dist = filled ? DW'(avg_prod >> SH) : in_raw;
        end

        if (!sid_valid) begin
            n_dist  = '0;
            n_stale = 1'b0;
            n_rej   = '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blind_zone  <= rof_pkg::RST_BLIND_ZONE;
            r_max_range   <= rof_pkg::RST_MAX_RANGE;
            r_max_change  <= rof_pkg::RST_MAX_CHANGE;
            r_max_rejects <= rof_pkg::RST_MAX_REJECTS;
            r_expire_ms   <= rof_pkg::RST_EXPIRE_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rof_pkg::CFG_BLIND_ZONE:  r_blind_zone  <= i_cfg_wdata[DW-1:0];
                rof_pkg::CFG_MAX_RANGE:   r_max_range   <= i_cfg_wdata[DW-1:0];
                rof_pkg::CFG_MAX_CHANGE:  r_max_change  <= i_cfg_wdata[DW-1:0];
                rof_pkg::CFG_MAX_REJECTS: r_max_rejects <= i_cfg_wdata[CW-1:0];
                rof_pkg::CFG_EXPIRE_MS:   r_expire_ms   <= i_cfg_wdata[rof_pkg::EXP_W-1:0];
                default: ;
            endcase
        end
    end

    // sensor control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_has    <= '0;
            r_stale  <= '0;
            for (int s = 0; s < SENSORS; s++) begin
                r_pos[s]  <= '0;
                r_sum[s]  <= '0;
                r_last[s] <= '0;
                r_ms[s]   <= '0;
                r_rej[s]  <= '0;
            end
        end else if (s_fire && sid_valid) begin
            r_stale[sel] <= n_stale;
            r_rej[sel]   <= n_rej;
            if (in_ok) begin
                r_ms[sel] <= in_now;
            end
            if (do_accept) begin
                r_last[sel]   <= in_raw;
                r_has[sel]    <= 1'b1;
                r_filled[sel] <= 1'b1;
                r_sum[sel]    <= n_sum;
                if (r_filled[sel]) begin
                    r_pos[sel] <= n_pos;
                end
            end
        end
    end

    // sample ring, contents only meaningful once the row is filled
    always_ff @(posedge i_clk) begin
        if (s_fire && sid_valid && do_accept) begin
            if (r_filled[sel]) begin
                r_ring[sel][r_pos[sel]] <= in_raw;
            end else begin
                for (int k = 0; k < FILTER_DEPTH; k++) begin
                    r_ring[sel][k] <= in_raw;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_sid   <= in_sid;
            r_out_dist  <= n_dist;
            r_out_stale <= n_stale;
            r_out_rej   <= n_rej;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(rof_pkg::M_TDATA_W - DW - CW){1'b0}}, r_out_rej, r_out_dist};
    assign m_axis_tuser  = {r_out_stale, r_out_sid};

`ifndef SYNTHESIS
    // ring fill and first acceptance always happen together
    a_has_matches_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has == r_filled)
        else $error("has_accepted and ring_filled disagree");

    // a transfer in always leaves a result the next cycle
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> m_axis_tvalid)
        else $error("input transfer produced no result");

    // a successful reading always reports not stale
    a_ok_not_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && in_ok) |=> !m_axis_tuser[2])
        else $error("successful reading reported stale");

    // an empty result register never blocks the input side
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty result register");
`endif

endmodule

// File: verif/tb_range_outlier_filter_core.sv
// tb_range_outlier_filter_core: self-checking bench for the range outlier filter
// drives s_axis, checks every m_axis transfer against typed rows or a model
// depends on rof_pkg and range_outlier_filter_core
module tb_range_outlier_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SID_W           = rof_pkg::SID_W;
    localparam int unsigned DIST_W          = rof_pkg::DIST_W;
    localparam int unsigned CNT_W           = rof_pkg::CNT_W;
    localparam int unsigned MS_W            = rof_pkg::MS_W;
    localparam int unsigned EXP_W           = rof_pkg::EXP_W;
    localparam int unsigned CFG_AW          = rof_pkg::CFG_AW;
    localparam int unsigned CFG_DW          = rof_pkg::CFG_DW;
    localparam int unsigned S_TDATA_W       = rof_pkg::S_TDATA_W;
    localparam int unsigned S_TUSER_W       = rof_pkg::S_TUSER_W;
    localparam int unsigned M_TDATA_W       = rof_pkg::M_TDATA_W;
    localparam int unsigned M_TUSER_W       = rof_pkg::M_TUSER_W;

    localparam int unsigned SENSORS         = rof_pkg::SENSORS_DEF;
    localparam int unsigned DEPTH           = rof_pkg::FILTER_DEPTH_DEF;
    localparam int unsigned DIST_MAX        = (1 << DIST_W) - 1;
    localparam int unsigned IDLE_LIMIT      = 4000;
    localparam int unsigned N_PHASES        = 5;
    localparam int unsigned ITEMS_PER_PHASE = 180;
    localparam logic        TYPED           = 1'b1;
    localparam logic        PREDICTED       = 1'b0;

    typedef struct packed {
        logic [SID_W-1:0]  sid;
        logic              ok;
        logic [DIST_W-1:0] raw;
        logic [MS_W-1:0]   now;
    } t_reading;

    typedef struct packed {
        logic [SID_W-1:0]  sid;
        logic [DIST_W-1:0] distance;
        logic              stale;
        logic [CNT_W-1:0]  rejects;
    } t_result;

    typedef struct packed {
        t_reading rd;
        logic     typed;
        t_result  want;
    } t_dir_row;

    typedef struct packed {
        logic [DIST_W-1:0] blind;
        logic [DIST_W-1:0] max_range;
        logic [DIST_W-1:0] max_change;
        logic [CNT_W-1:0]  max_rej;
        logic [EXP_W-1:0]  expire;
    } t_reg_set;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr    = '0;
    logic [CFG_DW-1:0]    i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // filter model state
    logic [DIST_W-1:0] ring [SENSORS][DEPTH];
    int unsigned       ring_pos [SENSORS];
    logic              ring_full [SENSORS];
    logic [DIST_W-1:0] last_acc [SENSORS];
    logic              has_acc [SENSORS];
    logic [MS_W-1:0]   last_ok_ms [SENSORS];
    logic              stale_q [SENSORS];
    logic [CNT_W-1:0]  rej_cnt [SENSORS];

    logic [DIST_W-1:0] cfg_blind;
    logic [DIST_W-1:0] cfg_max_range;
    logic [DIST_W-1:0] cfg_max_change;
    logic [CNT_W-1:0]  cfg_max_rej;
    logic [EXP_W-1:0]  cfg_expire;

    t_result           expected_q [$];
    int unsigned       mismatches  = 0;
    int unsigned       idle_cycles = 0;
    logic [MS_W-1:0]   ms_clock    = '0;
    bit                steady      = 1'b0;

    always #2 i_clk = ~i_clk;

    range_outlier_filter_core #(
        .SENSORS      (SENSORS),
        .FILTER_DEPTH (DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic void reset_filter_model();
        for (int s = 0; s < SENSORS; s++) begin
            for (int i = 0; i < DEPTH; i++) ring[s][i] = '0;
            ring_pos[s]   = 0;
            ring_full[s]  = 1'b0;
            last_acc[s]   = '0;
            has_acc[s]    = 1'b0;
            last_ok_ms[s] = '0;
            stale_q[s]    = 1'b0;
            rej_cnt[s]    = '0;
        end
        cfg_blind      = rof_pkg::RST_BLIND_ZONE;
        cfg_max_range  = rof_pkg::RST_MAX_RANGE;
        cfg_max_change = rof_pkg::RST_MAX_CHANGE;
        cfg_max_rej    = rof_pkg::RST_MAX_REJECTS;
        cfg_expire     = rof_pkg::RST_EXPIRE_MS;
    endfunction

    // accepted reading: clear rejects, enter the moving average
    function automatic logic [DIST_W-1:0] take_reading(input int unsigned s,
                                                       input logic [DIST_W-1:0] v);
        int unsigned total;
        rej_cnt[s]  = '0;
        last_acc[s] = v;
        has_acc[s]  = 1'b1;
        if (!ring_full[s]) begin
            for (int i = 0; i < DEPTH; i++) ring[s][i] = v;
            ring_full[s] = 1'b1;
            return v;
        end
        ring[s][ring_pos[s]] = v;
        ring_pos[s] = (ring_pos[s] + 1) % DEPTH;
        total = 0;
        for (int i = 0; i < DEPTH; i++) total += 32'(ring[s][i]);
        return DIST_W'(total / DEPTH);
    endfunction

    function automatic t_result filter_reading(input t_reading rd);
        int unsigned       s;
        logic [DIST_W-1:0] distance;
        logic [DIST_W-1:0] jump;
        logic [MS_W-1:0]   since_ok;
        s = 32'(rd.sid);
        if (s >= SENSORS) return '{sid: rd.sid, distance: '0, stale: 1'b0, rejects: '0};
        distance = '0;
        if (rd.ok) begin
            last_ok_ms[s] = rd.now;
            stale_q[s]    = 1'b0;
            if (rd.raw < cfg_blind || rd.raw > cfg_max_range) begin
                rej_cnt[s] = rej_cnt[s] + 1'b1;
                if (rej_cnt[s] < cfg_max_rej && has_acc[s]) distance = last_acc[s];
                else distance = take_reading(s, rd.raw);
            end else begin
                jump = (rd.raw > last_acc[s]) ? rd.raw - last_acc[s] : last_acc[s] - rd.raw;
                if (has_acc[s] && jump > cfg_max_change) begin
                    rej_cnt[s] = rej_cnt[s] + 1'b1;
                    if (rej_cnt[s] < cfg_max_rej) distance = last_acc[s];
                    else distance = take_reading(s, rd.raw);
                end else begin
                    distance = take_reading(s, rd.raw);
                end
            end
        end else if (has_acc[s]) begin
            distance = last_acc[s];
            since_ok = rd.now - last_ok_ms[s];
            if (since_ok > MS_W'(cfg_expire)) stale_q[s] = 1'b1;
        end
        return '{sid: rd.sid, distance: distance, stale: stale_q[s], rejects: rej_cnt[s]};
    endfunction

    function automatic t_dir_row dir_row(input logic [SID_W-1:0] sid, input logic ok,
                                         input logic [DIST_W-1:0] raw,
                                         input logic [MS_W-1:0] now, input logic typed,
                                         input logic [DIST_W-1:0] distance,
                                         input logic stale,
                                         input logic [CNT_W-1:0] rej);
        return '{rd: '{sid: sid, ok: ok, raw: raw, now: now}, typed: typed,
                 want: '{sid: sid, distance: distance, stale: stale, rejects: rej}};
    endfunction

    function automatic t_reading random_reading();
        t_reading    rd;
        int unsigned pick;
        int          span;
        int          delta;
        int          v;
        rd.sid = SID_W'($urandom_range(0, SENSORS - 1));
        if ($urandom_range(0, 3) == 0) ms_clock += $urandom_range(0, 2 * cfg_expire + 8);
        else ms_clock += $urandom_range(0, 4);
        if ($urandom_range(0, 99) == 0) ms_clock = $urandom();
        rd.now = ms_clock;
        pick   = $urandom_range(0, 99);
        rd.ok  = (pick >= 12);
        rd.raw = DIST_W'($urandom());
        if (pick >= 12 && pick < 58) begin
            // near the last accepted value, straddling the jump limit
            span  = int'(cfg_max_change) + int'(cfg_max_change >> 3) + 4;
            delta = int'($urandom_range(0, span));
            if ($urandom_range(0, 1) == 1) delta = -delta;
            v = int'(last_acc[rd.sid]) + delta;
            if (v < 0) v = 0;
            if (v > int'(DIST_MAX)) v = DIST_MAX;
            rd.raw = DIST_W'(v);
        end else if (pick >= 58 && pick < 72) begin
            if (cfg_blind <= cfg_max_range)
                rd.raw = DIST_W'($urandom_range(cfg_blind, cfg_max_range));
        end else if (pick >= 72 && pick < 86) begin
            if ($urandom_range(0, 1) == 1 && cfg_blind != 0)
                rd.raw = DIST_W'($urandom_range(0, cfg_blind - 1));
            else if (cfg_max_range != DIST_MAX)
                rd.raw = DIST_W'($urandom_range(cfg_max_range + 1, DIST_MAX));
        end
        return rd;
    endfunction

    // reading far from the last accepted one, to pile up rejections
    function automatic t_reading outlier_reading(input logic [SID_W-1:0] sid);
        ms_clock += 1;
        return '{sid: sid, ok: 1'b1,
                 raw: (last_acc[sid] < (DIST_MAX + 1) / 2) ? DIST_W'(DIST_MAX) : '0,
                 now: ms_clock};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %0d at %0t: %s got %0d expected %0d",
                 mismatches, $time, what, got, want);
    endtask

    task automatic send_reading(input t_reading rd, input logic typed, input t_result want);
        int unsigned gap;
        t_result     pred;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({rd.now, rd.raw});
        s_axis_tuser  <= S_TUSER_W'({rd.ok, rd.sid});
        do @(posedge i_clk); while (!s_axis_tready);
        pred = filter_reading(rd);
        expected_q.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            rof_pkg::CFG_BLIND_ZONE:  cfg_blind      = DIST_W'(val);
            rof_pkg::CFG_MAX_RANGE:   cfg_max_range  = DIST_W'(val);
            rof_pkg::CFG_MAX_CHANGE:  cfg_max_change = DIST_W'(val);
            rof_pkg::CFG_MAX_REJECTS: cfg_max_rej    = CNT_W'(val);
            rof_pkg::CFG_EXPIRE_MS:   cfg_expire     = EXP_W'(val);
            default: ;
        endcase
    endtask

    task automatic load_regs(input t_reg_set rs);
        write_reg(rof_pkg::CFG_BLIND_ZONE, CFG_DW'(rs.blind));
        write_reg(rof_pkg::CFG_MAX_RANGE, CFG_DW'(rs.max_range));
        write_reg(rof_pkg::CFG_MAX_CHANGE, CFG_DW'(rs.max_change));
        write_reg(rof_pkg::CFG_MAX_REJECTS, CFG_DW'(rs.max_rej));
        write_reg(rof_pkg::CFG_EXPIRE_MS, CFG_DW'(rs.expire));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        t_reg_set    sets [N_PHASES];
        t_dir_row    rows [$];
        logic [SID_W-1:0] jam_sid;
        int unsigned jam_len;

        sets[0] = '{17'd0, 17'd131071, 17'd131071, 8'd1, 16'd0};
        sets[1] = '{17'd2000, 17'd40000, 17'd500, 8'd3, 16'd50};
        sets[2] = '{17'd131071, 17'd131071, 17'd0, 8'd255, 16'd65535};
        // inverted window and a zero reject limit
        sets[3] = '{17'd10000, 17'd5000, 17'd2000, 8'd0, 16'd200};
        sets[4] = '{17'd100, 17'd100000, 17'd3000, 8'd8, 16'd1};

        // reset register values: first failure, first out-of-range fills ring,
        // forced acceptance after the limit, blind edge, stale edge and wrap
        rows.push_back(dir_row(2'd0, 1'b0, 17'd0, 32'd0, TYPED, 17'd0, 1'b0, 8'd0));
        rows.push_back(dir_row(2'd0, 1'b1, 17'd0, 32'd10, TYPED, 17'd0, 1'b0, 8'd0));
        rows.push_back(dir_row(2'd1, 1'b1, 17'd131071, 32'd20, TYPED, 17'd131071, 1'b0, 8'd0));
        rows.push_back(dir_row(2'd1, 1'b1, 17'd1000, 32'd30, TYPED, 17'd131071, 1'b0, 8'd1));
        rows.push_back(dir_row(2'd1, 1'b1, 17'd1000, 32'd31, TYPED, 17'd131071, 1'b0, 8'd2));
        rows.push_back(dir_row(2'd1, 1'b1, 17'd1000, 32'd32, TYPED, 17'd131071, 1'b0, 8'd3));
        rows.push_back(dir_row(2'd1, 1'b1, 17'd1000, 32'd33, TYPED, 17'd131071, 1'b0, 8'd4));
        rows.push_back(dir_row(2'd1, 1'b1, 17'd1000, 32'd34, PREDICTED, '0, 1'b0, '0));
        rows.push_back(dir_row(2'd2, 1'b1, 17'd320, 32'd100, TYPED, 17'd320, 1'b0, 8'd0));
        rows.push_back(dir_row(2'd2, 1'b1, 17'd8320, 32'd110, PREDICTED, '0, 1'b0, '0));
        rows.push_back(dir_row(2'd2, 1'b1, 17'd64000, 32'd120, TYPED, 17'd8320, 1'b0, 8'd1));
        rows.push_back(dir_row(2'd2, 1'b1, 17'd64001, 32'd130, TYPED, 17'd8320, 1'b0, 8'd2));
        rows.push_back(dir_row(2'd2, 1'b0, 17'd0, 32'd1130, TYPED, 17'd8320, 1'b0, 8'd2));
        rows.push_back(dir_row(2'd2, 1'b0, 17'd0, 32'd1131, TYPED, 17'd8320, 1'b1, 8'd2));
        rows.push_back(dir_row(2'd2, 1'b0, 17'd77, 32'd0, TYPED, 17'd8320, 1'b1, 8'd2));
        rows.push_back(dir_row(2'd2, 1'b1, 17'd8000, 32'd5, PREDICTED, '0, 1'b0, '0));
        rows.push_back(dir_row(2'd3, 1'b0, 17'd131071, 32'hFFFF_FFFF, TYPED,
                               17'd0, 1'b0, 8'd0));
        rows.push_back(dir_row(2'd3, 1'b1, 17'd5000, 32'hFFFF_FFF0, TYPED,
                               17'd5000, 1'b0, 8'd0));
        rows.push_back(dir_row(2'd3, 1'b0, 17'd0, 32'h0000_03D8, TYPED, 17'd5000, 1'b0, 8'd0));
        rows.push_back(dir_row(2'd3, 1'b0, 17'd0, 32'h0000_03D9, TYPED, 17'd5000, 1'b1, 8'd0));
        rows.push_back(dir_row(2'd0, 1'b1, 17'd65535, 32'd200, TYPED, 17'd0, 1'b0, 8'd1));
        rows.push_back(dir_row(2'd0, 1'b1, 17'd319, 32'd201, TYPED, 17'd0, 1'b0, 8'd2));
        rows.push_back(dir_row(2'd0, 1'b1, 17'd8000, 32'd202, PREDICTED, '0, 1'b0, '0));

        reset_filter_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_reading(rows[k].rd, rows[k].typed, rows[k].want);
        drain_results();

        for (int p = 0; p < N_PHASES; p++) begin
            load_regs(sets[p]);
            if (p == 2) ms_clock = 32'hFFFF_FF00;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
                // hold the sender until the pipe is empty
                if (k == ITEMS_PER_PHASE / 2) drain_results();
                if (k == 10 || $urandom_range(0, 49) == 0) begin
                    jam_sid = SID_W'($urandom_range(0, SENSORS - 1));
                    jam_len = (k == 10) ? sets[p].max_rej + 2
                                        : $urandom_range(1, sets[p].max_rej % 16 + 3);
                    for (int j = 0; j < jam_len; j++)
                        send_reading(outlier_reading(jam_sid), PREDICTED, '0);
                end
                send_reading(random_reading(), PREDICTED, '0);
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        t_result     got;
        t_result     want;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = '{sid: m_axis_tuser[SID_W-1:0], distance: m_axis_tdata[DIST_W-1:0],
                    stale: m_axis_tuser[SID_W], rejects: m_axis_tdata[DIST_W +: CNT_W]};
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing pending, distance",
                                32'(got.distance), 0);
            end else begin
                want = expected_q.pop_front();
                if (got.sid != want.sid)
                    report_mismatch("sensor id", 32'(got.sid), 32'(want.sid));
                if (got.distance != want.distance)
                    report_mismatch("distance", 32'(got.distance), 32'(want.distance));
                if (got.stale != want.stale)
                    report_mismatch("stale", 32'(got.stale), 32'(want.stale));
                if (got.rejects != want.rejects)
                    report_mismatch("reject count", 32'(got.rejects), 32'(want.rejects));
            end
        end
    end

    // ends the run if no transfer or register write happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
